// File: hw/rtl/tpt_pkg.sv
package tpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int FRAME_COUNT = 256;
  localparam int OFFSET_BITS = 8;
  localparam int PAGE_BITS   = 8;

  localparam int ADDR_W     = 16;
  localparam int COUNT_W    = 32;
  localparam int PAGE_SPACE = 1 << PAGE_BITS;
  localparam int FRAME_W    = $clog2(FRAME_COUNT);
  localparam int NEXT_W     = $clog2(FRAME_COUNT + 1);
  localparam int TLB_IDX_W  = $clog2(TLB_ENTRIES);
  localparam int TLB_CNT_W  = $clog2(TLB_ENTRIES + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_t;

  // TLB lookup result for the page held in the work register
  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlb_rsp_t;

  // TLB insert request: promote or append as most recently used
  typedef struct packed {
    logic               en;
    logic [FRAME_W-1:0] frame;
  } tlb_upd_t;

  // Page table read data, registered: valid the cycle after the read
  typedef struct packed {
    logic               present;
    logic [FRAME_W-1:0] frame;
  } pt_rsp_t;

  // Page table write of a newly allocated frame
  typedef struct packed {
    logic                 en;
    logic [PAGE_BITS-1:0] page;
    logic [FRAME_W-1:0]   frame;
  } pt_wr_t;

endpackage

// File: hw/rtl/tlb_page_table_translator_top.sv
// Virtual address translator: 16-entry LRU TLB in front of a page table.
//
// Input word: in_logical_address (page above the offset), handshake in_valid
// / in_stall. Result word: physical address, tlb_hit, page_fault,
// out_of_frames and saturating hit and fault totals, handshake out_valid /
// out_stall. One result per input word.
//
// An accepted word reads the page table in its accept cycle; the lookup state
// that follows compares the TLB, resolves the frame, writes the page table on a
// fault and loads the output register together with out_valid.
// A new word is taken only after the lookup has finished: the page table read
// is followed by its write-back. in_stall is high during the lookup state, so
// the next word can never see a page table entry before its write-back.
//
// A result waiting in the output register does not block acceptance; if it
// is still stalled when the next lookup completes, that lookup holds until
// the register frees up.
//
// Reset (synchronous, rst_n low) empties the TLB, clears all page table
// present bits, restarts frame allocation at frame 0 and zeroes the totals.
// No clearing pass: the block accepts a word the cycle after reset.
module tlb_page_table_translator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tpt_pkg::ADDR_W-1:0]  in_logical_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tpt_pkg::ADDR_W-1:0]  out_physical_address,
  output logic                        out_tlb_hit,
  output logic                        out_page_fault,
  output logic                        out_out_of_frames,
  output logic [tpt_pkg::COUNT_W-1:0] out_hits_so_far,
  output logic [tpt_pkg::COUNT_W-1:0] out_faults_so_far
);
  import tpt_pkg::*;

  state_t state_r, state_nxt;

  logic [31:0]            addr_ext;
  logic [PAGE_BITS-1:0]   in_page;
  logic [PAGE_BITS-1:0]   page_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic                   in_acc;
  logic                   done;

  tlb_rsp_t tlb_rsp;
  tlb_upd_t tlb_upd;
  pt_rsp_t  pt_rsp;
  pt_wr_t   pt_wr;

  logic [NEXT_W-1:0]  next_free_r, next_free_nxt;
  logic [COUNT_W-1:0] hits_r, hits_nxt;
  logic [COUNT_W-1:0] faults_r, faults_nxt;

  logic               need_alloc;
  logic               no_frame;
  logic               alloc;
  logic [FRAME_W-1:0] frame;
  logic [31:0]        phys_ext;

  logic               out_valid_r;
  logic [ADDR_W-1:0]  out_phys_r;
  logic               out_hit_r;
  logic               out_fault_r;
  logic               out_oof_r;
  logic [COUNT_W-1:0] out_hits_r;
  logic [COUNT_W-1:0] out_faults_r;

  assign addr_ext = 32'(in_logical_address);
  assign in_page  = addr_ext[OFFSET_BITS +: PAGE_BITS];
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign done     = (state_r == S_LOOK) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_LOOK;
      S_LOOK:  if (done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r   <= in_page;
      offset_r <= addr_ext[OFFSET_BITS-1:0];
    end
  end

  tpt_page_table u_page_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_page (in_page),
    .rsp     (pt_rsp),
    .wr      (pt_wr)
  );

  tpt_tlb u_tlb (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_page (page_r),
    .rsp         (tlb_rsp),
    .upd         (tlb_upd)
  );

  // resolve: TLB, then page table, then allocate
  always_comb begin
    need_alloc = !tlb_rsp.hit && !pt_rsp.present;
    no_frame   = need_alloc && (next_free_r == NEXT_W'(FRAME_COUNT));
    alloc      = need_alloc && !no_frame;
    if (tlb_rsp.hit) begin
      frame = tlb_rsp.frame;
    end else if (pt_rsp.present) begin
      frame = pt_rsp.frame;
    end else begin
      frame = next_free_r[FRAME_W-1:0];
    end
    phys_ext = (32'(frame) << OFFSET_BITS) | 32'(offset_r);

    tlb_upd.en    = done && !no_frame;
    tlb_upd.frame = frame;
    pt_wr.en      = done && alloc;
    pt_wr.page    = page_r;
    pt_wr.frame   = frame;

    next_free_nxt = next_free_r + NEXT_W'(alloc);
    hits_nxt      = hits_r;
    faults_nxt    = faults_r;
    if (tlb_rsp.hit && hits_r != COUNT_MAX) begin
      hits_nxt = hits_r + COUNT_W'(1);
    end
    if (need_alloc && faults_r != COUNT_MAX) begin
      faults_nxt = faults_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_free_r <= '0;
      hits_r      <= '0;
      faults_r    <= '0;
    end else if (done) begin
      next_free_r <= next_free_nxt;
      hits_r      <= hits_nxt;
      faults_r    <= faults_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_phys_r   <= no_frame ? '0 : phys_ext[ADDR_W-1:0];
      out_hit_r    <= tlb_rsp.hit;
      out_fault_r  <= alloc;
      out_oof_r    <= no_frame;
      out_hits_r   <= hits_nxt;
      out_faults_r <= faults_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_phys_r;
  assign out_tlb_hit          = out_hit_r;
  assign out_page_fault       = out_fault_r;
  assign out_out_of_frames    = out_oof_r;
  assign out_hits_so_far      = out_hits_r;
  assign out_faults_so_far    = out_faults_r;

endmodule

// File: hw/rtl/tpt_tlb.sv
module tpt_tlb (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tpt_pkg::PAGE_BITS-1:0] lookup_page,
  output tpt_pkg::tlb_rsp_t             rsp,
  input  tpt_pkg::tlb_upd_t             upd
);
  import tpt_pkg::*;

  logic [PAGE_BITS-1:0] slot_page_r  [TLB_ENTRIES];
  logic [FRAME_W-1:0]   slot_frame_r [TLB_ENTRIES];
  logic [PAGE_BITS-1:0] slot_page_nxt  [TLB_ENTRIES];
  logic [FRAME_W-1:0]   slot_frame_nxt [TLB_ENTRIES];
  logic [TLB_CNT_W-1:0] filled_r, filled_nxt;

  logic                 hit;
  logic [TLB_IDX_W-1:0] hit_idx;
  logic [FRAME_W-1:0]   hit_frame;
  logic                 full;
  logic                 drop;
  logic [TLB_CNT_W-1:0] rm_pos;
  logic [TLB_CNT_W-1:0] keep_cnt;

  // parallel compare over the valid slots; pages are unique among them
  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    hit_frame = '0;
    for (int j = 0; j < TLB_ENTRIES; j++) begin
      if (TLB_CNT_W'(j) < filled_r && slot_page_r[j] == lookup_page) begin
        hit       = 1'b1;
        hit_idx   = hit_idx | TLB_IDX_W'(j);
        hit_frame = hit_frame | slot_frame_r[j];
      end
    end
  end

  assign rsp.hit   = hit;
  assign rsp.frame = hit_frame;

  // slot 0 is LRU; remove the hit slot (or evict slot 0 when full), close
  // the gap and place the entry at the top
  always_comb begin
    full     = (filled_r == TLB_CNT_W'(TLB_ENTRIES));
    drop     = hit || full;
    rm_pos   = hit ? TLB_CNT_W'(hit_idx) : (full ? '0 : filled_r);
    keep_cnt = filled_r - TLB_CNT_W'(drop);
    for (int j = 0; j < TLB_ENTRIES; j++) begin
      slot_page_nxt[j]  = slot_page_r[j];
      slot_frame_nxt[j] = slot_frame_r[j];
      if (TLB_CNT_W'(j) >= rm_pos && TLB_CNT_W'(j) < keep_cnt) begin
        if (j < TLB_ENTRIES - 1) begin
          slot_page_nxt[j]  = slot_page_r[j+1];
          slot_frame_nxt[j] = slot_frame_r[j+1];
        end
      end else if (TLB_CNT_W'(j) == keep_cnt) begin
        slot_page_nxt[j]  = lookup_page;
        slot_frame_nxt[j] = upd.frame;
      end
    end
    filled_nxt = keep_cnt + TLB_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
    end else if (upd.en) begin
      filled_r <= filled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en) begin
      slot_page_r  <= slot_page_nxt;
      slot_frame_r <= slot_frame_nxt;
    end
  end

endmodule

// File: hw/rtl/tpt_page_table.sv
module tpt_page_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [tpt_pkg::PAGE_BITS-1:0] rd_page,
  output tpt_pkg::pt_rsp_t              rsp,
  input  tpt_pkg::pt_wr_t               wr
);
  import tpt_pkg::*;

  logic [FRAME_W-1:0]    frame_mem [PAGE_SPACE];
  logic [PAGE_SPACE-1:0] present_r;
  logic                  rd_present_r;
  logic [FRAME_W-1:0]    rd_frame_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (wr.en) begin
      present_r[wr.page] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      frame_mem[wr.page] <= wr.frame;
    end
  end

  // frame data is only meaningful where the present bit is set
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_frame_r   <= frame_mem[rd_page];
      rd_present_r <= present_r[rd_page];
    end
  end

  assign rsp.present = rd_present_r;
  assign rsp.frame   = rd_frame_r;

endmodule

// File: hw/rtl/tpt_checker.sv
module tpt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [tpt_pkg::ADDR_W-1:0]  out_physical_address,
  input logic                        out_tlb_hit,
  input logic                        out_page_fault,
  input logic                        out_out_of_frames,
  input logic [tpt_pkg::COUNT_W-1:0] out_hits_so_far,
  input logic [tpt_pkg::COUNT_W-1:0] out_faults_so_far
);
  import tpt_pkg::*;

  // a result that is stalled stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  // each accepted word is followed by a lookup cycle with the input closed
  a_one_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted during lookup");

  // hit, fault and out-of-frames exclude one another
  a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_tlb_hit, out_page_fault, out_out_of_frames}))
    else $error("conflicting lookup outcome");

  // no frame means no address; any fault or hit is counted
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_out_of_frames || out_physical_address == '0) &&
                  (!out_tlb_hit || out_hits_so_far != '0) &&
                  (!(out_page_fault || out_out_of_frames) || out_faults_so_far != '0))
    else $error("result flags disagree with address or totals");

endmodule

bind tlb_page_table_translator_top tpt_checker u_tpt_checker (.*);
